FILE: design/blrf_pkg.sv
// ----------------------------------------------------------------------------
// blrf_pkg: shared definitions for the bitmap longest run finder
// Register indexes, search modes, field widths and default size limits.
// ----------------------------------------------------------------------------
package blrf_pkg;

	// Default limits of the image size.
	localparam int MAX_ROWS_DEF = 1024;
	localparam int MAX_COLS_DEF = 1024;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 2'd2;

	localparam logic MODE_HORIZONTAL = 1'b0;
	localparam logic MODE_VERTICAL   = 1'b1;

	// Stream payloads.
	localparam int COORD_W     = 10;
	localparam int IN_TDATA_W  = 8;
	localparam int RESULT_W    = 1 + 4 * COORD_W;
	localparam int OUT_TDATA_W = 48;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] end_row;
		logic [COORD_W-1:0] end_col;
	} result_t;

endpackage

FILE: design/blrf_col_store.sv
// ----------------------------------------------------------------------------
// blrf_col_store: per-column vertical run store
// Holds run length and start row of every column in one memory. A fill count
// marks the columns written in the current image; others read as empty.
// ----------------------------------------------------------------------------
module blrf_col_store #(
	parameter int MAX_ROWS = blrf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = blrf_pkg::MAX_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
	input  logic                        rd_clear,
	input  logic                        wr_en,
	input  logic [$clog2(MAX_COLS)-1:0] wr_addr,
	input  logic [$clog2(MAX_ROWS+1)-1:0] wr_len,
	input  logic [$clog2(MAX_ROWS)-1:0] wr_start,
	output logic [$clog2(MAX_ROWS+1)-1:0] rd_len,
	output logic [$clog2(MAX_ROWS)-1:0] rd_start
);

	localparam int FW = $clog2(MAX_COLS + 1);
	localparam int LW = $clog2(MAX_ROWS + 1);
	localparam int PW = $clog2(MAX_ROWS);
	localparam int WW = LW + PW;

	logic [WW-1:0] mem [MAX_COLS];
	logic [WW-1:0] rd_word_q;
	logic [WW-1:0] fwd_word_q;
	logic [WW-1:0] wr_word;
	logic [WW-1:0] eff_word;
	logic          fwd_q;
	logic          hit_q;
	logic [FW-1:0] fill_q;

	assign wr_word = {wr_len, wr_start};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q  <= mem[rd_addr];
			fwd_word_q <= wr_word;
		end
	end

	// Columns are visited in order from zero, so every column below the fill
	// count has been written during the current image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= 1'b0;
			hit_q  <= 1'b0;
			fill_q <= '0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
			hit_q <= FW'(rd_addr) < fill_q;
			if (rd_clear) begin
				fill_q <= '0;
			end else if (FW'(rd_addr) >= fill_q) begin
				fill_q <= FW'(rd_addr) + FW'(1);
			end
		end
	end

	assign eff_word = !hit_q ? '0 : (fwd_q ? fwd_word_q : rd_word_q);
	assign rd_len   = eff_word[WW-1:PW];
	assign rd_start = eff_word[PW-1:0];

endmodule

FILE: design/bitmap_longest_run_finder_unit.sv
// ----------------------------------------------------------------------------
// bitmap_longest_run_finder_unit: longest run of set pixels in a bitmap
// Takes a monochrome bitmap one pixel per beat in row-major order and reports
// the longest horizontal or vertical run of set pixels after the last pixel.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake                     | Payload
//  ---------+-----+-------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[0] pixel
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: found, start_row,
//           |     |                               | start_col, end_row, end_col
//  cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One pixel is accepted every cycle. A pixel enters the input stage, where its
// row and column are assigned and its column entry is read from the column
// store; in the second stage the run trackers and the best run are updated and
// the column entry is written back. The single result of an image is loaded
// into the output register as its last pixel leaves the second stage. Only a
// last pixel can stall, and only while the previous result still waits in the
// output register. After reset the block needs no clearing time: the column
// store tracks which columns the current image has written, and the sizes
// reset to one row and one column in horizontal mode.
//
module bitmap_longest_run_finder_unit #(
	parameter int MAX_ROWS = blrf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = blrf_pkg::MAX_COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Pixel stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [blrf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] pixel, rest zero
	// Result stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [blrf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [0] found,
	                                                          // [10:1] start_row,
	                                                          // [20:11] start_col,
	                                                          // [30:21] end_row,
	                                                          // [40:31] end_col
	// Register writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [blrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int PW  = $clog2(MAX_ROWS);      // row position
	localparam int CPW = $clog2(MAX_COLS);      // column position
	localparam int RW  = $clog2(MAX_ROWS + 1);  // row count, vertical run length
	localparam int CW  = $clog2(MAX_COLS + 1);  // column count, horizontal run length
	localparam int BLW = (RW > CW) ? RW : CW;   // best run length
	localparam int PAD = blrf_pkg::OUT_TDATA_W - blrf_pkg::RESULT_W;

	// ------------------------------------------------------------------------
	// Configuration. Sizes are kept already clamped to 1..MAX.
	// ------------------------------------------------------------------------
	logic [RW-1:0] rows_q;
	logic [CW-1:0] cols_q;
	logic          mode_q;
	logic [RW-1:0] cfg_rows;
	logic [CW-1:0] cfg_cols;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_rows = RW'(1);
		end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
			cfg_rows = RW'(MAX_ROWS);
		end else begin
			cfg_rows = RW'(cfg_data);
		end
		if (cfg_data == '0) begin
			cfg_cols = CW'(1);
		end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
			cfg_cols = CW'(MAX_COLS);
		end else begin
			cfg_cols = CW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW'(1);
			cols_q <= CW'(1);
			mode_q <= blrf_pkg::MODE_HORIZONTAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				blrf_pkg::REG_IMAGE_ROWS:  rows_q <= cfg_rows;
				blrf_pkg::REG_IMAGE_COLS:  cols_q <= cfg_cols;
				blrf_pkg::REG_SEARCH_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Input stage: scan position and column store read.
	// ------------------------------------------------------------------------
	logic [PW-1:0]  row_q;
	logic [CPW-1:0] col_q;
	logic           in_accept;
	logic           last_col;
	logic           last_row;

	logic           valid_s1;
	logic           pixel_s1;
	logic [PW-1:0]  row_s1;
	logic [CPW-1:0] col_s1;
	logic           last_col_s1;
	logic           last_row_s1;
	logic           adv_s1;
	logic           out_free;

	// A position at or past the last column or row is treated as the last one,
	// which keeps the scan consistent when a size shrinks mid-image.
	assign last_col  = (CW + 1)'(col_q) + (CW + 1)'(1) >= (CW + 1)'(cols_q);
	assign last_row  = (RW + 1)'(row_q) + (RW + 1)'(1) >= (RW + 1)'(rows_q);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv_s1        = valid_s1 && (!(last_col_s1 && last_row_s1) || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				if (!last_col) begin
					col_q <= col_q + CPW'(1);
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + PW'(1);
				end
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1    <= s_axis_tdata[0];
			row_s1      <= row_q;
			col_s1      <= col_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	// ------------------------------------------------------------------------
	// Column store: run length and start row per column.
	// ------------------------------------------------------------------------
	logic [RW-1:0] col_len;
	logic [PW-1:0] col_start;
	logic [RW-1:0] v_len;
	logic [PW-1:0] v_start;
	logic [PW-1:0] v_end;
	logic          v_close;

	blrf_col_store #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_col_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (col_q),
		.rd_clear (last_col && last_row),
		.wr_en    (adv_s1),
		.wr_addr  (col_s1),
		.wr_len   (v_close ? '0 : v_len),
		.wr_start (v_start),
		.rd_len   (col_len),
		.rd_start (col_start)
	);

	// ------------------------------------------------------------------------
	// Second stage: run trackers and best run.
	// ------------------------------------------------------------------------
	logic [CW-1:0]  hrun_len_q;
	logic [CPW-1:0] hrun_start_q;
	logic [CW-1:0]  h_len;
	logic [CPW-1:0] h_start;
	logic [CPW-1:0] h_end;
	logic           h_close;

	logic [BLW-1:0] best_len_q;
	logic [PW-1:0]  best_sr_q;
	logic [CPW-1:0] best_sc_q;
	logic [PW-1:0]  best_er_q;
	logic [CPW-1:0] best_ec_q;

	logic           h_take;
	logic           v_take;
	logic           v_tie_wins;
	logic [BLW-1:0] nb_len;
	logic [PW-1:0]  nb_sr;
	logic [CPW-1:0] nb_sc;
	logic [PW-1:0]  nb_er;
	logic [CPW-1:0] nb_ec;
	logic           img_end_s1;

	blrf_pkg::result_t result;
	blrf_pkg::result_t out_q;

	assign img_end_s1 = last_col_s1 && last_row_s1;

	always_comb begin
		// Horizontal tracker: a run closes on a clear pixel or at the row end,
		// and its end is the last set pixel.
		h_start = hrun_start_q;
		h_len   = hrun_len_q;
		if (pixel_s1) begin
			if (hrun_len_q == '0) begin
				h_start = col_s1;
			end
			h_len = hrun_len_q + CW'(1);
		end
		h_close = (h_len != '0) && (!pixel_s1 || last_col_s1);
		h_end   = pixel_s1 ? col_s1 : col_s1 - CPW'(1);

		// Vertical tracker for the current column.
		v_start = col_start;
		v_len   = col_len;
		if (pixel_s1) begin
			if (col_len == '0) begin
				v_start = row_s1;
			end
			v_len = col_len + RW'(1);
		end
		v_close = (v_len != '0) && (!pixel_s1 || last_row_s1);
		v_end   = pixel_s1 ? row_s1 : row_s1 - PW'(1);

		// Vertical ties go to the lower column, then the lower start row.
		v_tie_wins = (BLW'(v_len) == best_len_q) &&
		             ((col_s1 < best_sc_q) || ((col_s1 == best_sc_q) && (v_start < best_sr_q)));
		h_take = (mode_q == blrf_pkg::MODE_HORIZONTAL) && h_close &&
		         (BLW'(h_len) > best_len_q);
		v_take = (mode_q == blrf_pkg::MODE_VERTICAL) && v_close &&
		         ((BLW'(v_len) > best_len_q) || v_tie_wins);

		nb_len = best_len_q;
		nb_sr  = best_sr_q;
		nb_sc  = best_sc_q;
		nb_er  = best_er_q;
		nb_ec  = best_ec_q;
		if (h_take) begin
			nb_len = BLW'(h_len);
			nb_sr  = row_s1;
			nb_sc  = h_start;
			nb_er  = row_s1;
			nb_ec  = h_end;
		end else if (v_take) begin
			nb_len = BLW'(v_len);
			nb_sr  = v_start;
			nb_sc  = col_s1;
			nb_er  = v_end;
			nb_ec  = col_s1;
		end

		// A single pixel is not a run: report nothing and zero coordinates.
		if (nb_len >= BLW'(2)) begin
			result.found     = 1'b1;
			result.start_row = blrf_pkg::COORD_W'(nb_sr);
			result.start_col = blrf_pkg::COORD_W'(nb_sc);
			result.end_row   = blrf_pkg::COORD_W'(nb_er);
			result.end_col   = blrf_pkg::COORD_W'(nb_ec);
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hrun_len_q   <= '0;
			hrun_start_q <= '0;
			best_len_q   <= '0;
			best_sr_q    <= '0;
			best_sc_q    <= '0;
			best_er_q    <= '0;
			best_ec_q    <= '0;
		end else if (adv_s1) begin
			hrun_start_q <= h_start;
			hrun_len_q   <= h_close ? '0 : h_len;
			if (img_end_s1) begin
				best_len_q <= '0;
				best_sr_q  <= '0;
				best_sc_q  <= '0;
				best_er_q  <= '0;
				best_ec_q  <= '0;
			end else begin
				best_len_q <= nb_len;
				best_sr_q  <= nb_sr;
				best_sc_q  <= nb_sc;
				best_er_q  <= nb_er;
				best_ec_q  <= nb_ec;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_s1 && img_end_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && img_end_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tdata = {{PAD{1'b0}}, out_q.end_col, out_q.end_row,
	                       out_q.start_col, out_q.start_row, out_q.found};

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_end_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && img_end_s1 |=> m_axis_tvalid)
		else $error("image end did not load the output register");

	a_pos_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && last_col && last_row |=> (row_q == '0) && (col_q == '0))
		else $error("scan position not cleared at image end");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !out_q.found |->
			(out_q.start_row == '0) && (out_q.start_col == '0) &&
			(out_q.end_row == '0) && (out_q.end_col == '0))
		else $error("coordinates reported without a run");

	a_run_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.found && (MAX_ROWS <= 1024) && (MAX_COLS <= 1024) |->
			(out_q.start_row <= out_q.end_row) && (out_q.start_col <= out_q.end_col))
		else $error("run ends before it starts");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && img_end_s1 |=> (best_len_q == '0) && (hrun_len_q == '0))
		else $error("trackers not cleared at image end");

endmodule

FILE: tb/blrf_tb_pkg.sv
// ----------------------------------------------------------------------------
// blrf_tb_pkg: scoreboard for the bitmap longest run finder
// Tracks horizontal and vertical runs of set pixels as the block should, and
// checks each result beat against the oldest predicted run.
// ----------------------------------------------------------------------------
package blrf_tb_pkg;

	import blrf_pkg::*;

	typedef struct packed {
		bit               found;
		bit [COORD_W-1:0] start_row;
		bit [COORD_W-1:0] start_col;
		bit [COORD_W-1:0] end_row;
		bit [COORD_W-1:0] end_col;
	} run_result_t;

	class longest_run_scoreboard;

		bit [CFG_DATA_W-1:0] rows_cfg;
		bit [CFG_DATA_W-1:0] cols_cfg;
		bit                  mode_cfg;

		bit [COORD_W-1:0] row_pos;
		bit [COORD_W-1:0] col_pos;
		bit [COORD_W:0]   hrun_len;
		bit [COORD_W-1:0] hrun_start;
		bit [COORD_W:0]   vrun_len [MAX_COLS_DEF];
		bit [COORD_W-1:0] vrun_start [MAX_COLS_DEF];
		bit [COORD_W:0]   best_len;
		run_result_t      best;

		run_result_t pending_runs [$];
		int          n_errors;

		function new();
			rows_cfg = 1;
			cols_cfg = 1;
			mode_cfg = MODE_HORIZONTAL;
			foreach (vrun_start[i])
				vrun_start[i] = '0;
			clear_image();
		endfunction

		function void clear_image();
			row_pos = '0;
			col_pos = '0;
			hrun_len = '0;
			hrun_start = '0;
			foreach (vrun_len[i])
				vrun_len[i] = '0;
			best_len = '0;
			best = '0;
		endfunction

		// A size of zero means one; sizes past the limit saturate.
		static function int clamp_size(bit [CFG_DATA_W-1:0] v, int lim);
			if (v == 0)
				return 1;
			return (int'(v) > lim) ? lim : int'(v);
		endfunction

		function int rows_now();
			return clamp_size(rows_cfg, MAX_ROWS_DEF);
		endfunction

		function int cols_now();
			return clamp_size(cols_cfg, MAX_COLS_DEF);
		endfunction

		function int pending();
			return pending_runs.size();
		endfunction

		function int errors();
			return n_errors;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_ROWS:  rows_cfg = data;
				REG_IMAGE_COLS:  cols_cfg = data;
				REG_SEARCH_MODE: mode_cfg = data[0];
				default: ;
			endcase
		endfunction

		function void take_best(bit [COORD_W:0] len, bit [COORD_W-1:0] sr,
				bit [COORD_W-1:0] sc, bit [COORD_W-1:0] er, bit [COORD_W-1:0] ec);
			best_len = len;
			best.start_row = sr;
			best.start_col = sc;
			best.end_row = er;
			best.end_col = ec;
		endfunction

		// Called for every accepted pixel beat.
		function void note_pixel(bit px);
			bit [COORD_W-1:0] r;
			bit [COORD_W-1:0] c;
			bit [COORD_W-1:0] end_pos;
			bit               last_col;
			bit               last_row;
			run_result_t      res;
			r = row_pos;
			c = col_pos;
			last_col = (int'(c) + 1 >= cols_now());
			last_row = (int'(r) + 1 >= rows_now());

			// Horizontal run closes on a clear pixel or at the row end.
			if (px) begin
				if (hrun_len == 0)
					hrun_start = c;
				hrun_len++;
			end
			if (hrun_len != 0 && (!px || last_col)) begin
				end_pos = px ? c : c - 1'b1;
				if (mode_cfg == MODE_HORIZONTAL && hrun_len > best_len)
					take_best(hrun_len, r, hrun_start, r, end_pos);
				hrun_len = '0;
			end

			// Vertical run of this column; ties go to lower column, then lower row.
			if (px) begin
				if (vrun_len[c] == 0)
					vrun_start[c] = r;
				vrun_len[c]++;
			end
			if (vrun_len[c] != 0 && (!px || last_row)) begin
				end_pos = px ? r : r - 1'b1;
				if (mode_cfg == MODE_VERTICAL && (vrun_len[c] > best_len ||
						(vrun_len[c] == best_len && (c < best.start_col ||
						(c == best.start_col && vrun_start[c] < best.start_row)))))
					take_best(vrun_len[c], vrun_start[c], c, end_pos, c);
				vrun_len[c] = '0;
			end

			if (!last_col) begin
				col_pos = c + 1'b1;
				return;
			end
			col_pos = '0;
			if (!last_row) begin
				row_pos = r + 1'b1;
				return;
			end

			// Last pixel of the image: one result, then a fresh image.
			res = '0;
			if (best_len >= 2) begin
				res = best;
				res.found = 1'b1;
			end
			pending_runs.push_back(res);
			clear_image();
		endfunction

		function void report(string what, run_result_t exp_run, run_result_t act_run);
			n_errors++;
			if (n_errors <= 10)
				$display("%0t: %s: expected found=%0b (%0d,%0d)-(%0d,%0d), got found=%0b (%0d,%0d)-(%0d,%0d)",
					$realtime, what, exp_run.found, exp_run.start_row, exp_run.start_col,
					exp_run.end_row, exp_run.end_col, act_run.found, act_run.start_row,
					act_run.start_col, act_run.end_row, act_run.end_col);
		endfunction

		// Called for every accepted result beat.
		function void check_result(logic [OUT_TDATA_W-1:0] beat);
			run_result_t act_run;
			run_result_t exp_run;
			act_run.found = beat[0];
			act_run.start_row = beat[10:1];
			act_run.start_col = beat[20:11];
			act_run.end_row = beat[30:21];
			act_run.end_col = beat[40:31];
			if (pending_runs.size() == 0) begin
				report("result with no image finished", '0, act_run);
				return;
			end
			exp_run = pending_runs.pop_front();
			if (beat[0] !== exp_run.found || beat[10:1] !== exp_run.start_row ||
					beat[20:11] !== exp_run.start_col || beat[30:21] !== exp_run.end_row ||
					beat[40:31] !== exp_run.end_col || beat[OUT_TDATA_W-1:41] !== '0)
				report("result mismatch", exp_run, act_run);
		endfunction

	endclass

endpackage

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of bitmap_longest_run_finder_unit
// Streams bitmaps one pixel per beat in bursts and checks each reported run
// against a scoreboard: small directed images, size extremes, sizes and mode
// changed part way through an image, then many random small images.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import blrf_pkg::*;
	import blrf_tb_pkg::*;

	// Index that selects no register; writes to it must leave the block alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Cycles to let the pipeline drain after the last expected result, with margin.
	localparam int SETTLE_CYCLES = 6;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	longest_run_scoreboard runs = new();

	int burst_left = 0;
	int n_pixels = 0;
	int stall_pct = 0;
	int stall_phase = 0;

	bitmap_longest_run_finder_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check every accepted beat, then pick the next ready value.
	// The stall rate is redrawn whenever stall_phase wraps, from never stalling
	// to stalling most of the time, so results wait on a busy sink in stretches.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			runs.check_result(m_axis_tdata);
		if (stall_phase == 0) begin
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		stall_phase = (stall_phase + 1) % 48;
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one pixel and hold it until the block takes the beat. The sender
	// works in bursts; between bursts it may drop valid, and now and then a long
	// burst runs with no gap at all.
	task automatic send_pixel(input bit px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(300, 100)
				: $urandom_range(40, 1);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, px};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		runs.note_pixel(px);
		n_pixels++;
		burst_left--;
	endtask

	// Valid is left high so that writes can go back to back; cfg_release
	// drops it once a batch of writes is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		runs.write_reg(idx, data);
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
	endtask

	task automatic set_image(input int n_rows, input int n_cols, input logic mode);
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(n_rows));
		write_reg(REG_IMAGE_COLS, CFG_DATA_W'(n_cols));
		write_reg(REG_SEARCH_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
		cfg_release();
	endtask

	// Stop the pixel stream and let every outstanding result drain, so that
	// registers can be written while the block is quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (runs.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pixels written as text in row-major order; spaces only aid reading.
	task automatic send_bits(input string pattern);
		for (int i = 0; i < pattern.len(); i++) begin
			if (pattern[i] == "1")
				send_pixel(1'b1);
			else if (pattern[i] == "0")
				send_pixel(1'b0);
		end
	endtask

	// A whole image at the current size: random noise at the given density
	// with a few straight segments drawn over it, so that long runs and ties
	// between equal runs turn up often.
	task automatic send_image(input int density, input int n_lines);
		int h;
		int w;
		int rr;
		int cc;
		int len;
		bit img [];
		h = runs.rows_now();
		w = runs.cols_now();
		img = new[h * w];
		foreach (img[i])
			img[i] = ($urandom_range(99) < density);
		repeat (n_lines) begin
			rr = $urandom_range(h - 1);
			cc = $urandom_range(w - 1);
			if ($urandom_range(1)) begin
				len = $urandom_range(w - cc, 1);
				for (int k = 0; k < len; k++)
					img[rr * w + cc + k] = 1'b1;
			end else begin
				len = $urandom_range(h - rr, 1);
				for (int k = 0; k < len; k++)
					img[(rr + k) * w + cc] = 1'b1;
			end
		end
		foreach (img[i])
			send_pixel(img[i]);
	endtask

	// The first part of an image, stopping short of its last pixel.
	task automatic send_partial(input int count, input int density);
		repeat (count)
			send_pixel($urandom_range(99) < density);
	endtask

	// Random pixels until the image in progress is complete.
	task automatic finish_image(input int density);
		while (runs.pending() == 0)
			send_pixel($urandom_range(99) < density);
	endtask

	function automatic int pick_size();
		case ($urandom_range(11))
			0: return 0;
			1: return 1;
			2: return 2;
			10: return $urandom_range(16, 9);
			11: return $urandom_range(32, 17);
			default: return $urandom_range(8, 1);
		endcase
	endfunction

	function automatic int pick_density();
		case ($urandom_range(7))
			0: return 0;
			1: return 100;
			default: return $urandom_range(90, 10);
		endcase
	endfunction

	initial begin
		int random_start;
		int density;
		int which;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: a one-pixel image in horizontal mode never finds a run.
		send_bits("1");
		send_bits("0");
		settle();

		// A run that closes at the end of its row.
		set_image(1, 2, MODE_HORIZONTAL);
		send_bits("11");
		settle();

		// Two equal horizontal runs: the earlier one wins.
		set_image(2, 3, MODE_HORIZONTAL);
		send_bits("011 110");
		settle();

		// The run in column one closes first, but an equal run in column zero
		// closing later still wins, as in column-major order.
		set_image(4, 2, MODE_VERTICAL);
		send_bits("01 11 10 00");
		settle();

		// Only single-pixel runs: nothing found.
		set_image(3, 3, MODE_VERTICAL);
		send_bits("100 010 001");
		settle();

		// Size extremes. Zero acts as one, oversize saturates to the largest
		// image, and only bit zero selects the mode. Full-width and
		// full-height runs reach the largest coordinates.
		write_reg(REG_IMAGE_ROWS, '0);
		write_reg(REG_IMAGE_COLS, '1);
		write_reg(REG_SEARCH_MODE, 11'h7FE);
		cfg_release();
		send_image(100, 0);
		settle();
		write_reg(REG_IMAGE_ROWS, '1);
		write_reg(REG_IMAGE_COLS, '0);
		write_reg(REG_SEARCH_MODE, 11'h7FF);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2047)));
		cfg_release();
		send_image(100, 0);
		settle();

		// Changes in the middle of an image: fewer columns with a mode switch,
		// fewer rows than already passed, and a mode switch alone.
		set_image(6, 6, MODE_HORIZONTAL);
		send_partial(15, 60);
		settle();
		write_reg(REG_IMAGE_COLS, CFG_DATA_W'(3));
		write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_VERTICAL));
		cfg_release();
		finish_image(60);
		settle();
		set_image(8, 5, MODE_VERTICAL);
		send_partial(30, 70);
		settle();
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(2));
		cfg_release();
		finish_image(70);
		settle();
		set_image(5, 5, MODE_VERTICAL);
		send_partial(12, 70);
		settle();
		write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_HORIZONTAL));
		cfg_release();
		finish_image(70);

		// Random images, mostly small so that many results come out. Half the
		// time the size and mode stay, and images follow back to back.
		random_start = n_pixels;
		while (n_pixels - random_start < 1600) begin
			density = pick_density();
			if ($urandom_range(1)) begin
				settle();
				set_image(pick_size(), pick_size(), 1'($urandom_range(1)));
			end
			if ($urandom_range(9) == 0) begin
				send_partial($urandom_range(runs.rows_now() * runs.cols_now() - 1),
					density);
				settle();
				which = $urandom_range(2);
				case (which)
					0: write_reg(REG_IMAGE_ROWS, CFG_DATA_W'($urandom_range(12)));
					1: write_reg(REG_IMAGE_COLS, CFG_DATA_W'($urandom_range(12)));
					default: write_reg(REG_SEARCH_MODE, CFG_DATA_W'($urandom_range(1)));
				endcase
				cfg_release();
				finish_image(density);
			end else begin
				send_image(density, $urandom_range(3));
			end
		end

		s_axis_tvalid <= 1'b0;
		while (runs.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (runs.errors() == 0 && runs.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
design/blrf_pkg.sv
design/blrf_col_store.sv
design/bitmap_longest_run_finder_unit.sv
tb/blrf_tb_pkg.sv
tb/tb.sv
